### sv/ges_pkg.sv
// Package for the Gaussian elimination solver: item types, codes, sizing constants.
package ges_pkg;

  localparam int unsigned SystemOrderDefault = 4;
  localparam int unsigned RowIdxW = 2;
  localparam int unsigned ColIdxW = 3;
  localparam int unsigned DataW   = 32;

  localparam logic [1:0] StatusOk    = 2'd0;
  localparam logic [1:0] StatusPivot = 2'd1;
  localparam logic [1:0] StatusOvf   = 2'd2;

  typedef struct packed {
    logic [RowIdxW-1:0]     row_index;
    logic [ColIdxW-1:0]     column_index;
    logic signed [DataW-1:0] coefficient;
    logic                   load_done;
  } ges_in_t;

  typedef struct packed {
    logic [RowIdxW-1:0]      unknown_index;
    logic signed [DataW-1:0] solution;
    logic [1:0]              status;
    logic                    last_result;
  } ges_out_t;

endpackage

### sv/ges_div.sv
// Restoring signed divider: truncating quotient of a 64-bit dividend by a 32-bit divisor.
module ges_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [63:0] dividend_i,
  input  logic signed [31:0] divisor_i,
  output logic               done_o,
  output logic signed [64:0] quotient_o
);

  logic [63:0] num_q, num_d;
  logic [31:0] den_q, den_d;
  logic [64:0] rem_q, rem_d;
  logic        neg_q, neg_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [64:0] trial;

  always_comb begin
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[63:0], num_q[63]} - {33'd0, den_q};
    if (start_i) begin
      num_d  = dividend_i[63] ? 64'(-dividend_i) : dividend_i;
      den_d  = divisor_i[31] ? 32'(-divisor_i) : divisor_i;
      neg_d  = dividend_i[63] ^ divisor_i[31];
      rem_d  = '0;
      cnt_d  = 7'd0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      // quotient bits shift into num from the bottom
      if (!trial[64]) begin
        rem_d = trial;
        num_d = {num_q[62:0], 1'b1};
      end else begin
        rem_d = {rem_q[63:0], num_q[63]};
        num_d = {num_q[62:0], 1'b0};
      end
      cnt_d = cnt_q + 7'd1;
      if (cnt_q == 7'd63) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
    neg_q <= neg_d;
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? -$signed({1'b0, num_q}) : $signed({1'b0, num_q});

endmodule

### sv/gaussian_elimination_solver.sv
// Top level of the Gaussian elimination solver (no pivoting, back substitution).
//
//  channel | ports                      | accepted when
//  load    | start_i, busy_o, item_i    | start_i && !busy_o
//  result  | result_valid_o, result_o   | every cycle result_valid_o is high
//
// A load without load_done leaves the solver idle. A load with load_done starts a solve
// that walks the matrix memory with one 64-step serial divider and updates each matrix
// entry by a read-modify-write. Results come one per cycle at its end.
// Reset clears the controller and flags only; matrix entries are undefined until loaded.
// The receiver cannot stall; busy_o is high from the final load until the last result.
module gaussian_elimination_solver #(
  parameter int unsigned SYSTEM_ORDER = ges_pkg::SystemOrderDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  ges_pkg::ges_in_t  item_i,
  output logic              busy_o,
  output logic              result_valid_o,
  output ges_pkg::ges_out_t result_o
);

  localparam int unsigned Cols  = SYSTEM_ORDER + 1;
  localparam int unsigned Depth = SYSTEM_ORDER * Cols;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned IdxW  = $clog2(Cols + 1);
  localparam int unsigned SolW  = $clog2(SYSTEM_ORDER);

  typedef enum logic [14:0] {
    S_IDLE  = 15'h0001,
    S_KPIV  = 15'h0002,
    S_KPIVW = 15'h0004,
    S_RDCK  = 15'h0008,
    S_DIV   = 15'h0010,
    S_RDKI  = 15'h0020,
    S_RDCI  = 15'h0040,
    S_MUL   = 15'h0080,
    S_WRCI  = 15'h0100,
    S_BRHS  = 15'h0200,
    S_BPIV  = 15'h0400,
    S_BRIJ  = 15'h0800,
    S_BMUL  = 15'h1000,
    S_BDIV  = 15'h2000,
    S_OUT   = 15'h4000
  } state_e;

  state_e state_q, state_d;

  logic signed [31:0] mem [Depth];
  logic signed [31:0] rdata_q;
  logic [AddrW-1:0]   raddr;
  logic               we;
  logic [AddrW-1:0]   waddr;
  logic signed [31:0] wdata;

  logic signed [31:0] sol_q [SYSTEM_ORDER];
  logic [IdxW-1:0] k_q, k_d, c_q, c_d, i_q, i_d;
  logic signed [31:0] piv_q, piv_d, m_q, m_d, opa_q, opa_d, cur_q, cur_d;
  logic signed [63:0] acc_q, acc_d;
  logic signed [63:0] prod_q;
  logic [1:0] flags_q, flags_d;
  logic       div_start;
  logic signed [63:0] div_num;
  logic       div_done;
  logic signed [64:0] div_quo;
  logic       sol_we;
  logic signed [31:0] sol_wd;

  function automatic logic [AddrW-1:0] addr_of(logic [IdxW-1:0] r, logic [IdxW-1:0] c);
    logic [AddrW+IdxW:0] a;
    a = (AddrW+IdxW+1)'(r) * (AddrW+IdxW+1)'(Cols) + (AddrW+IdxW+1)'(c);
    return a[AddrW-1:0];
  endfunction

  function automatic logic signed [31:0] sat(logic signed [65:0] v, output logic ovf);
    logic signed [31:0] r;
    ovf = 1'b0;
    r   = v[31:0];
    if (v > 66'sd2147483647) begin
      ovf = 1'b1;
      r   = 32'sh7fffffff;
    end else if (v < -66'sd2147483648) begin
      ovf = 1'b1;
      r   = 32'sh80000000;
    end
    return r;
  endfunction

  // truncating divide of product by 2^16
  function automatic logic signed [63:0] qscale(logic signed [63:0] p);
    logic signed [63:0] b;
    b = p + (p[63] ? 64'sd65535 : 64'sd0);
    return b >>> 16;
  endfunction

  ges_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_num),
    .divisor_i (piv_q),
    .done_o    (div_done),
    .quotient_o(div_quo)
  );

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];
    prod_q  <= opa_q * m_q;
    if (sol_we) sol_q[c_q[SolW-1:0]] <= sol_wd;
  end

  logic load_ok;
  assign load_ok = (32'(item_i.row_index) < 32'(SYSTEM_ORDER)) &&
                   (32'(item_i.column_index) <= 32'(SYSTEM_ORDER));

  always_comb begin
    logic ov;
    logic signed [31:0] s;
    state_d   = state_q;
    k_d = k_q; c_d = c_q; i_d = i_q;
    piv_d = piv_q; m_d = m_q; opa_d = opa_q; cur_d = cur_q; acc_d = acc_q;
    flags_d   = flags_q;
    raddr     = '0;
    we        = 1'b0;
    waddr     = '0;
    wdata     = '0;
    div_start = 1'b0;
    div_num   = acc_q;
    sol_we    = 1'b0;
    sol_wd    = '0;
    ov        = 1'b0;
    s         = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (load_ok) begin
            we    = 1'b1;
            waddr = addr_of(IdxW'(item_i.row_index), IdxW'(item_i.column_index));
            wdata = item_i.coefficient;
          end
          if (item_i.load_done) begin
            flags_d = '0;
            k_d     = '0;
            state_d = S_KPIV;
          end
        end
      end
      S_KPIV: begin
        if (32'(k_q) >= 32'(SYSTEM_ORDER - 1)) begin
          c_d     = IdxW'(SYSTEM_ORDER - 1);
          state_d = S_BRHS;
        end else begin
          raddr   = addr_of(k_q, k_q);
          state_d = S_KPIVW;
        end
      end
      S_KPIVW: begin
        piv_d = rdata_q;
        if (rdata_q == 0) begin
          flags_d[0] = 1'b1;
          k_d        = k_q + 1'b1;
          state_d    = S_KPIV;
        end else begin
          c_d     = k_q + 1'b1;
          state_d = S_RDCK;
        end
      end
      S_RDCK: begin
        if (32'(c_q) >= 32'(SYSTEM_ORDER)) begin
          k_d     = k_q + 1'b1;
          state_d = S_KPIV;
        end else begin
          raddr   = addr_of(c_q, k_q);
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (!div_done && acc_q != 64'sd1) begin
          div_num   = 64'(rdata_q) <<< 16;
          div_start = 1'b1;
          acc_d     = 64'sd1;  // marks divider launched
        end else if (div_done) begin
          s     = sat(66'(-div_quo), ov);
          flags_d[1] = flags_q[1] | ov;
          m_d   = s;
          acc_d = '0;
          we    = 1'b1;
          waddr = addr_of(c_q, k_q);
          wdata = '0;
          i_d   = k_q + 1'b1;
          state_d = S_RDKI;
        end
      end
      S_RDKI: begin
        if (32'(i_q) >= 32'(Cols)) begin
          c_d     = c_q + 1'b1;
          state_d = S_RDCK;
        end else begin
          raddr   = addr_of(k_q, i_q);
          state_d = S_RDCI;
        end
      end
      S_RDCI: begin
        opa_d   = rdata_q;
        raddr   = addr_of(c_q, i_q);
        state_d = S_MUL;
      end
      S_MUL: begin
        cur_d   = rdata_q;
        state_d = S_WRCI;
      end
      S_WRCI: begin
        s     = sat(66'(cur_q) + 66'(qscale(prod_q)), ov);
        flags_d[1] = flags_q[1] | ov;
        we    = 1'b1;
        waddr = addr_of(c_q, i_q);
        wdata = s;
        i_d   = i_q + 1'b1;
        state_d = S_RDKI;
      end
      S_BRHS: begin
        raddr   = addr_of(c_q, IdxW'(SYSTEM_ORDER));
        state_d = S_BPIV;
      end
      S_BPIV: begin
        acc_d   = 64'(rdata_q);
        cur_d   = '0;
        raddr   = addr_of(c_q, c_q);
        i_d     = c_q + 1'b1;
        state_d = S_BRIJ;
      end
      S_BRIJ: begin
        if (i_q == c_q + 1'b1) piv_d = rdata_q;
        if (32'(i_q) >= 32'(SYSTEM_ORDER)) begin
          state_d = S_BDIV;
          m_d     = '0;
        end else begin
          raddr   = addr_of(c_q, i_q);
          state_d = S_BMUL;
        end
      end
      S_BMUL: begin
        // three steps: capture operands, wait for the product, accumulate
        if (cur_q == 32'sd0) begin
          opa_d = rdata_q;
          m_d   = sol_q[i_q[SolW-1:0]];
          cur_d = 32'sd1;
        end else if (cur_q == 32'sd1) begin
          cur_d = 32'sd2;
        end else begin
          acc_d   = acc_q - qscale(prod_q);
          cur_d   = '0;
          i_d     = i_q + 1'b1;
          state_d = S_BRIJ;
        end
      end
      S_BDIV: begin
        if (piv_q == 0) begin
          flags_d[0] = 1'b1;
          sol_we     = 1'b1;
          sol_wd     = '0;
          state_d    = (c_q == '0) ? S_OUT : S_BRHS;
          c_d        = (c_q == '0) ? c_q : c_q - 1'b1;
          acc_d      = '0;
        end else if (!div_done && m_q == 0) begin
          s         = sat(66'(acc_q), ov);
          flags_d[1] = flags_q[1] | ov;
          div_num   = 64'(s) <<< 16;
          div_start = 1'b1;
          m_d       = 32'sd1;
        end else if (div_done) begin
          s      = sat(66'(div_quo), ov);
          flags_d[1] = flags_q[1] | ov;
          sol_we = 1'b1;
          sol_wd = s;
          acc_d  = '0;
          state_d = (c_q == '0) ? S_OUT : S_BRHS;
          c_d     = (c_q == '0) ? c_q : c_q - 1'b1;
        end
      end
      S_OUT: begin
        c_d = c_q + 1'b1;
        if (32'(c_q) == 32'(SYSTEM_ORDER - 1)) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // the solution write uses c_q; in S_OUT c walks 0..N-1 for the results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      flags_q <= '0;
      acc_q   <= '0;
      cur_q   <= '0;
    end else begin
      state_q <= state_d;
      flags_q <= flags_d;
      acc_q   <= acc_d;
      cur_q   <= cur_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q <= k_d; c_q <= c_d; i_q <= i_d;
    piv_q <= piv_d; m_q <= m_d; opa_q <= opa_d;
  end

  assign busy_o                 = (state_q != S_IDLE);
  assign result_valid_o         = (state_q == S_OUT);
  assign result_o.unknown_index = ges_pkg::RowIdxW'(c_q);
  assign result_o.solution      = sol_q[c_q[SolW-1:0]];
  assign result_o.status        = flags_q[0] ? ges_pkg::StatusPivot :
                                  (flags_q[1] ? ges_pkg::StatusOvf : ges_pkg::StatusOk);
  assign result_o.last_result   = (32'(c_q) == 32'(SYSTEM_ORDER - 1));

  a_out_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy_o) else $error("result while idle");
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.last_result) |=> !busy_o) else $error("no return to idle");
  a_idle_noout: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o |-> !result_valid_o) else $error("stray result");

endmodule

### tb/testbench.sv
// Self-checking testbench for the Gaussian elimination solver.
`timescale 1ns / 1ps

class solution_board;
  int unsigned n_order;
  logic signed [31:0] mat[4][5];
  logic signed [31:0] xsol[4];
  logic [1:0] flags;
  ges_pkg::ges_out_t pending[$];
  int unsigned errors;
  int unsigned solves;
  int unsigned status_seen[3];

  function new(int unsigned order);
    n_order = order;
    errors = 0;
    solves = 0;
  endfunction

  function automatic logic signed [31:0] sat(longint v);
    if (v > 64'sd2147483647) begin
      flags[1] = 1'b1;
      return 32'sh7fffffff;
    end
    if (v < -64'sd2147483648) begin
      flags[1] = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic longint qmul(longint a, longint b);
    return (a * b) / 65536;
  endfunction

  function automatic void solve_system();
    longint q, acc;
    logic signed [31:0] m, piv;
    flags = 2'b00;
    for (int k = 0; k < n_order - 1; k++) begin
      piv = mat[k][k];
      if (piv == 0) begin
        flags[0] = 1'b1;
        continue;
      end
      for (int c = k + 1; c < n_order; c++) begin
        q = (longint'(mat[c][k]) * 65536) / longint'(piv);
        m = sat(-q);
        mat[c][k] = 0;
        for (int i = k + 1; i <= n_order; i++)
          mat[c][i] = sat(longint'(mat[c][i]) + qmul(mat[k][i], m));
      end
    end
    for (int i = n_order - 1; i >= 0; i--) begin
      acc = mat[i][n_order];
      piv = mat[i][i];
      for (int j = i + 1; j < n_order; j++) acc -= qmul(mat[i][j], xsol[j]);
      acc = sat(acc);
      if (piv == 0) begin
        flags[0] = 1'b1;
        xsol[i] = 0;
      end else begin
        xsol[i] = sat((acc * 65536) / longint'(piv));
      end
    end
  endfunction

  function automatic void note_load(ges_pkg::ges_in_t it);
    ges_pkg::ges_out_t r;
    if (it.row_index < n_order && it.column_index <= n_order) begin
      mat[it.row_index][it.column_index] = it.coefficient;
    end
    if (!it.load_done) return;
    solve_system();
    solves++;
    for (int i = 0; i < n_order; i++) begin
      r.unknown_index = 2'(i);
      r.solution = xsol[i];
      r.status = flags[0] ? ges_pkg::StatusPivot :
                 flags[1] ? ges_pkg::StatusOvf : ges_pkg::StatusOk;
      r.last_result = (i == n_order - 1);
      pending.push_back(r);
    end
    status_seen[r.status]++;
  endfunction

  function automatic void check_result(ges_pkg::ges_out_t got);
    ges_pkg::ges_out_t exp_r;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result %p", $time, got);
      errors++;
      return;
    end
    exp_r = pending.pop_front();
    if (got !== exp_r) begin
      $display("%0t: mismatch expected %p actual %p", $time, exp_r, got);
      errors++;
    end
  endfunction
endclass

module testbench;

  localparam int unsigned Order = 4;
  localparam int unsigned IdleLimit = 20000;

  logic clk_i, rst_ni, start_i, busy_o, result_valid_o;
  ges_pkg::ges_in_t item_i;
  ges_pkg::ges_out_t result_o;
  solution_board board;
  int unsigned idle_cycles;
  int unsigned loads;

  gaussian_elimination_solver #(.SYSTEM_ORDER(Order)) uut (
    .clk_i, .rst_ni, .start_i, .item_i, .busy_o, .result_valid_o, .result_o
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_o) board.check_result(result_o);
      if (start_i && !busy_o) begin
        board.note_load(item_i);
        loads++;
      end
      if ((start_i && !busy_o) || result_valid_o) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("%0t: watchdog expired", $time);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Burst/gap pacing: gap only at the start of a new burst.
  int unsigned burst_left;

  task automatic send_item(ges_pkg::ges_in_t it);
    int unsigned gap;
    @(negedge clk_i);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        start_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    item_i <= it;
    start_i <= 1'b1;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic load_entry(int r, int c, logic signed [31:0] v, bit done);
    ges_pkg::ges_in_t it;
    it.row_index = 2'(r);
    it.column_index = 3'(c);
    it.coefficient = v;
    it.load_done = done;
    send_item(it);
  endtask

  function automatic logic signed [31:0] rand_value(int style);
    case (style)
      0: return $signed($urandom_range(0, 8 << 16)) - (4 << 16);
      1: return $urandom;
      2: return ($urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000);
      default: return ($urandom_range(0, 3) == 0) ? 0 : $signed($urandom_range(1, 3) << 16);
    endcase
  endfunction

  // Full system in random order, then the last entry carries load_done.
  task automatic load_system(int style, bit diag_dominant);
    int cells[$];
    int idx, tmp;
    logic signed [31:0] v;
    for (int i = 0; i < Order * (Order + 1); i++) cells.push_back(i);
    for (int i = cells.size() - 1; i > 0; i--) begin
      idx = $urandom_range(0, i);
      tmp = cells[i];
      cells[i] = cells[idx];
      cells[idx] = tmp;
    end
    foreach (cells[n]) begin
      v = rand_value(style);
      if (diag_dominant && cells[n] / (Order + 1) == cells[n] % (Order + 1))
        v = $signed($urandom_range(8 << 16, 16 << 16)) * ($urandom_range(0, 1) ? 1 : -1);
      load_entry(cells[n] / (Order + 1), cells[n] % (Order + 1), v,
                 n == cells.size() - 1);
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  initial begin
    ges_pkg::ges_in_t junk;
    rst_ni = 1'b0;
    start_i = 1'b0;
    item_i = '0;
    idle_cycles = 0;
    loads = 0;
    burst_left = 0;
    board = new(Order);
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: identity system, then zero pivot, then out-of-range loads and extreme in-range values.
    for (int r = 0; r < Order; r++)
      for (int c = 0; c <= Order; c++)
        load_entry(r, c, (r == c) ? 32'sh10000 : (c == Order ? 32'sh7fffffff : 0),
                   r == Order - 1 && c == Order);
    load_entry(0, 0, 0, 1'b1);
    load_entry(3, 7, 32'sh80000000, 1'b0);
    load_entry(0, 5, 32'sh12345678, 1'b0);
    load_entry(0, 0, 32'sh80000000, 1'b0);
    load_entry(1, 1, 32'sh7fffffff, 1'b0);
    load_entry(2, 4, 32'sh80000000, 1'b1);
    drain();

    while (loads < 360) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: load_system(0, 1'b1);
        4: load_system(1, 1'b0);
        5: load_system(2, 1'b0);
        6: load_system(3, 1'b0);
        default: begin
          // Partial reload of a few entries, then solve again.
          repeat ($urandom_range(0, 5)) begin
            junk.row_index = 2'($urandom);
            junk.column_index = 3'($urandom);
            junk.coefficient = $urandom;
            junk.load_done = 1'b0;
            send_item(junk);
          end
          load_entry($urandom_range(0, Order - 1), $urandom_range(0, Order),
                     rand_value($urandom_range(0, 3)), 1'b1);
        end
      endcase
      if ($urandom_range(0, 4) == 0) drain();
    end
    drain();

    $display("Ran %0d loads over %0d solves; status ok/pivot/ovf runs: %0d/%0d/%0d.",
             loads, board.solves, board.status_seen[0], board.status_seen[1],
             board.status_seen[2]);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

### files.f
sv/ges_pkg.sv
sv/ges_div.sv
sv/gaussian_elimination_solver.sv
tb/testbench.sv
